/* hw/rtl/rrot_pkg.sv */
// Shared types and constants for the segment versus rectangle obstacle test.
package rrot_pkg;

    localparam int CoordW = 24;
    localparam int ExtW   = 23;
    localparam int DirW   = 16;
    localparam int CntW   = 5;
    localparam int IdxW   = 4;

    localparam int DiffW  = 28;
    localparam int OpaW   = 34;
    localparam int MulW   = OpaW + DiffW;
    localparam int ProdW  = 56;
    localparam int OffW   = 27;
    localparam int OffShift = 13;
    localparam int InvShift = 33;

    localparam logic [OpaW-1:0] InvThree  = 34'd2863311531;
    localparam logic [MulW-1:0] RoundBias = MulW'(4096);

    localparam logic [3:0] SetupLast = 4'd2;
    localparam logic [3:0] StepLast  = 4'd10;

    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_DX,
        MOP_DY,
        MOP_IW,
        MOP_IL,
        MOP_PX0,
        MOP_PX1,
        MOP_PX2,
        MOP_PX3,
        MOP_PY0,
        MOP_PY1,
        MOP_PY2,
        MOP_PY3
    } t_mop;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_FETCH,
        S_ENT,
        S_EVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CoordW-1:0] cx;
        logic [CoordW-1:0] cy;
        logic [ExtW-1:0]   w;
        logic [ExtW-1:0]   l;
    } t_entry;

    typedef struct packed {
        t_mop mop;
        logic load_query;
    } t_cmd;

    typedef struct packed {
        logic entry_hit;
    } t_status;

endpackage

/* hw/rtl/ray_rectangle_obstacle_test_core.sv */
// Top level of the segment versus rectangular obstacle test.
// A query scans n = min(active_count, MAX_OBSTACLES) entries from accept to
// o_valid, fewer when a hit ends the scan early.
// Each entry takes one table read plus ten products on the one shared
// multiplier, with fill and evaluate steps; one item is in work at a time.
// Reset (synchronous, active low) clears control and active_count; table contents
// stay undefined until written, with no clearing pass.
module ray_rectangle_obstacle_test_core #(
    parameter int MAX_OBSTACLES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_kind,
    input  logic [rrot_pkg::IdxW-1:0]          i_entry_index,
    input  logic signed [rrot_pkg::CoordW-1:0] i_center_x,
    input  logic signed [rrot_pkg::CoordW-1:0] i_center_y,
    input  logic [rrot_pkg::ExtW-1:0]          i_obstacle_width,
    input  logic [rrot_pkg::ExtW-1:0]          i_obstacle_length,
    input  logic signed [rrot_pkg::CoordW-1:0] i_start_x,
    input  logic signed [rrot_pkg::CoordW-1:0] i_start_y,
    input  logic signed [rrot_pkg::DirW-1:0]   i_dir_x,
    input  logic signed [rrot_pkg::DirW-1:0]   i_dir_y,
    input  logic [rrot_pkg::ExtW-1:0]          i_reach,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_hit,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rrot_pkg::CntW-1:0]          i_cfg_data
);
    import rrot_pkg::*;

    localparam int AddrW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam logic [8:0] MaxN = 9'(MAX_OBSTACLES);

    t_cmd             w_cmd;
    t_status          w_status;
    t_entry           w_wdata;
    t_entry           w_rdata;
    logic [AddrW-1:0] w_raddr;
    logic [8:0]       w_eidx9;
    logic             w_we;

    assign o_cfg_ready = 1'b1;

    assign w_eidx9 = {{(9-IdxW){1'b0}}, i_entry_index};
    assign w_we    = i_valid && !o_stall && !i_kind && (w_eidx9 < MaxN);

    assign w_wdata.cx = i_center_x;
    assign w_wdata.cy = i_center_y;
    assign w_wdata.w  = i_obstacle_width;
    assign w_wdata.l  = i_obstacle_length;

    rrot_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_OBSTACLES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_eidx9[AddrW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rrot_ctrl #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_out_stall (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_status    (w_status),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_out_hit   (o_hit),
        .o_raddr     (w_raddr),
        .o_cmd       (w_cmd)
    );

    rrot_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_entry   (w_rdata),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_dir_x   (i_dir_x),
        .i_dir_y   (i_dir_y),
        .i_reach   (i_reach),
        .o_status  (w_status)
    );

endmodule

/* hw/rtl/rrot_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rrot_ram #(
    parameter int WIDTH = 94,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rrot_datapath.sv */
// Datapath: shared multiplier, edge coordinates, products and crossing signs.
module rrot_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rrot_pkg::t_cmd                 i_cmd,
    input  rrot_pkg::t_entry               i_entry,
    input  logic [rrot_pkg::CoordW-1:0]    i_start_x,
    input  logic [rrot_pkg::CoordW-1:0]    i_start_y,
    input  logic [rrot_pkg::DirW-1:0]      i_dir_x,
    input  logic [rrot_pkg::DirW-1:0]      i_dir_y,
    input  logic [rrot_pkg::ExtW-1:0]      i_reach,
    output rrot_pkg::t_status              o_status
);
    import rrot_pkg::*;

    logic [CoordW-1:0] r_sx;
    logic [CoordW-1:0] r_sy;
    logic [DirW-1:0]   r_dirx;
    logic [DirW-1:0]   r_diry;
    logic [ExtW-1:0]   r_reach;

    logic signed [MulW-1:0]  r_prod;
    t_mop                    r_wb_op;
    logic [OffW-1:0]         r_dxo;
    logic [OffW-1:0]         r_dyo;
    logic [ExtW-1:0]         r_iw;
    logic [ExtW-1:0]         r_il;
    logic signed [ProdW-1:0] r_px [4];
    logic [3:0]              r_sidex;
    logic [3:0]              r_sidey;
    logic [1:0]              r_gt [4];
    logic [1:0]              r_lt [4];

    logic signed [DiffW-1:0] w_p0x;
    logic signed [DiffW-1:0] w_p0y;
    logic signed [DiffW-1:0] w_cx2;
    logic signed [DiffW-1:0] w_cy2;
    logic signed [DiffW-1:0] w_hw;
    logic signed [DiffW-1:0] w_hl;
    logic signed [DiffW-1:0] w_iwx;
    logic signed [DiffW-1:0] w_ily;
    logic signed [DiffW-1:0] w_x [4];
    logic signed [DiffW-1:0] w_y [4];
    logic signed [DiffW-1:0] w_dxo_e;
    logic signed [DiffW-1:0] w_dyo_e;
    logic [ExtW+3:0]         w_w10;
    logic [ExtW+3:0]         w_l10;
    logic [ExtW+1:0]         w_mw;
    logic [ExtW+1:0]         w_ml;

    logic signed [OpaW-1:0]  w_a;
    logic signed [DiffW-1:0] w_b;
    logic signed [DiffW-1:0] w_soff;
    logic                    w_px_iss;
    logic                    w_py_iss;
    logic [1:0]              w_iss_k;
    logic                    w_side;

    logic [MulW-1:0]         w_rnd;
    logic signed [ProdW-1:0] w_py;
    logic                    w_py_wb;
    logic                    w_px_wb;
    logic [1:0]              w_wb_k;

    assign w_p0x = {{(DiffW-CoordW-1){r_sx[CoordW-1]}}, r_sx, 1'b0};
    assign w_p0y = {{(DiffW-CoordW-1){r_sy[CoordW-1]}}, r_sy, 1'b0};
    assign w_cx2 = {{(DiffW-CoordW-1){i_entry.cx[CoordW-1]}}, i_entry.cx, 1'b0};
    assign w_cy2 = {{(DiffW-CoordW-1){i_entry.cy[CoordW-1]}}, i_entry.cy, 1'b0};
    assign w_hw  = {{(DiffW-ExtW){1'b0}}, i_entry.w};
    assign w_hl  = {{(DiffW-ExtW){1'b0}}, i_entry.l};
    assign w_iwx = {{(DiffW-ExtW){1'b0}}, r_iw};
    assign w_ily = {{(DiffW-ExtW){1'b0}}, r_il};

    assign w_dxo_e = {{(DiffW-OffW){r_dxo[OffW-1]}}, r_dxo};
    assign w_dyo_e = {{(DiffW-OffW){r_dyo[OffW-1]}}, r_dyo};

    // 10 * extent + 6, then divide by 4; the divide by 3 runs on the multiplier
    assign w_w10 = {1'b0, i_entry.w, 3'b000} + {3'b000, i_entry.w, 1'b0} + (ExtW+4)'(6);
    assign w_l10 = {1'b0, i_entry.l, 3'b000} + {3'b000, i_entry.l, 1'b0} + (ExtW+4)'(6);
    assign w_mw  = w_w10[ExtW+3:2];
    assign w_ml  = w_l10[ExtW+3:2];

    always_comb begin
        w_x[0] = w_cx2 + w_hw;
        w_x[1] = w_cx2 - w_hw;
        w_x[2] = w_cx2 + w_iwx;
        w_x[3] = w_cx2 - w_iwx;
        w_y[0] = w_cy2 + w_hl;
        w_y[1] = w_cy2 - w_hl;
        w_y[2] = w_cy2 + w_ily;
        w_y[3] = w_cy2 - w_ily;
    end

    always_comb begin
        w_a      = '0;
        w_b      = '0;
        w_soff   = '0;
        w_px_iss = 1'b0;
        w_py_iss = 1'b0;
        w_iss_k  = 2'd0;
        case (i_cmd.mop)
            MOP_DX: begin
                w_a = {{(OpaW-DirW){r_dirx[DirW-1]}}, r_dirx};
                w_b = {{(DiffW-ExtW){1'b0}}, r_reach};
            end
            MOP_DY: begin
                w_a = {{(OpaW-DirW){r_diry[DirW-1]}}, r_diry};
                w_b = {{(DiffW-ExtW){1'b0}}, r_reach};
            end
            MOP_IW: begin
                w_a = InvThree;
                w_b = {{(DiffW-ExtW-2){1'b0}}, w_mw};
            end
            MOP_IL: begin
                w_a = InvThree;
                w_b = {{(DiffW-ExtW-2){1'b0}}, w_ml};
            end
            MOP_PX0: begin w_px_iss = 1'b1; w_iss_k = 2'd0; end
            MOP_PX1: begin w_px_iss = 1'b1; w_iss_k = 2'd1; end
            MOP_PX2: begin w_px_iss = 1'b1; w_iss_k = 2'd2; end
            MOP_PX3: begin w_px_iss = 1'b1; w_iss_k = 2'd3; end
            MOP_PY0: begin w_py_iss = 1'b1; w_iss_k = 2'd0; end
            MOP_PY1: begin w_py_iss = 1'b1; w_iss_k = 2'd1; end
            MOP_PY2: begin w_py_iss = 1'b1; w_iss_k = 2'd2; end
            MOP_PY3: begin w_py_iss = 1'b1; w_iss_k = 2'd3; end
            default: begin
                w_a = '0;
            end
        endcase
        if (w_px_iss) begin
            w_a    = {{(OpaW-OffW){r_dyo[OffW-1]}}, r_dyo};
            w_b    = w_x[w_iss_k] - w_p0x;
            w_soff = w_dxo_e;
        end
        if (w_py_iss) begin
            w_a    = {{(OpaW-OffW){r_dxo[OffW-1]}}, r_dxo};
            w_b    = w_y[w_iss_k] - w_p0y;
            w_soff = w_dyo_e;
        end
    end

    // start and end strictly on opposite sides of the edge line
    assign w_side = ((w_b > 0) && (w_soff > w_b)) || ((w_b < 0) && (w_soff < w_b));

    assign w_rnd = r_prod + RoundBias;
    assign w_py  = r_prod[ProdW-1:0];

    always_comb begin
        w_px_wb = 1'b0;
        w_py_wb = 1'b0;
        w_wb_k  = 2'd0;
        case (r_wb_op)
            MOP_PX0: begin w_px_wb = 1'b1; w_wb_k = 2'd0; end
            MOP_PX1: begin w_px_wb = 1'b1; w_wb_k = 2'd1; end
            MOP_PX2: begin w_px_wb = 1'b1; w_wb_k = 2'd2; end
            MOP_PX3: begin w_px_wb = 1'b1; w_wb_k = 2'd3; end
            MOP_PY0: begin w_py_wb = 1'b1; w_wb_k = 2'd0; end
            MOP_PY1: begin w_py_wb = 1'b1; w_wb_k = 2'd1; end
            MOP_PY2: begin w_py_wb = 1'b1; w_wb_k = 2'd2; end
            MOP_PY3: begin w_py_wb = 1'b1; w_wb_k = 2'd3; end
            default: begin
                w_wb_k = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_op <= MOP_NONE;
        end else begin
            r_wb_op <= i_cmd.mop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_sx    <= i_start_x;
            r_sy    <= i_start_y;
            r_dirx  <= i_dir_x;
            r_diry  <= i_dir_y;
            r_reach <= i_reach;
        end
        r_prod <= w_a * w_b;
        if (w_px_iss) begin
            r_sidex[w_iss_k] <= w_side;
        end
        if (w_py_iss) begin
            r_sidey[w_iss_k] <= w_side;
        end
        case (r_wb_op)
            MOP_DX:  r_dxo <= w_rnd[OffShift+OffW-1:OffShift];
            MOP_DY:  r_dyo <= w_rnd[OffShift+OffW-1:OffShift];
            MOP_IW:  r_iw  <= r_prod[InvShift+ExtW-1:InvShift];
            MOP_IL:  r_il  <= r_prod[InvShift+ExtW-1:InvShift];
            default: begin
            end
        endcase
        if (w_px_wb) begin
            r_px[w_wb_k] <= r_prod[ProdW-1:0];
        end
        if (w_py_wb) begin
            for (int k = 0; k < 2; k++) begin
                r_gt[w_wb_k][k] <= w_py > r_px[{w_wb_k[1], 1'(k)}];
                r_lt[w_wb_k][k] <= w_py < r_px[{w_wb_k[1], 1'(k)}];
            end
        end
    end

    always_comb begin
        logic [1:0] ya;
        logic [1:0] yb;
        logic [1:0] xi;
        logic       hit;
        hit = 1'b0;
        for (int g = 0; g < 2; g++) begin
            ya = {1'(g), 1'b0};
            yb = {1'(g), 1'b1};
            for (int k = 0; k < 2; k++) begin
                xi = {1'(g), 1'(k)};
                if (r_sidex[xi] &&
                    ((r_gt[ya][k] && r_lt[yb][k]) || (r_lt[ya][k] && r_gt[yb][k]))) begin
                    hit = 1'b1;
                end
            end
        end
        for (int j = 0; j < 4; j++) begin
            if (r_sidey[j] &&
                ((r_gt[j][0] && r_lt[j][1]) || (r_lt[j][0] && r_gt[j][1]))) begin
                hit = 1'b1;
            end
        end
        o_status.entry_hit = hit;
    end

endmodule

/* hw/rtl/rrot_ctrl.sv */
// Controller: query sequencing, entry scan, active count and result register.
module rrot_ctrl #(
    parameter int MAX_OBSTACLES = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  logic                                        i_kind,
    input  logic                                        i_out_stall,
    input  logic                                        i_cfg_valid,
    input  logic [rrot_pkg::CntW-1:0]                   i_cfg_data,
    input  rrot_pkg::t_status                           i_status,
    output logic                                        o_in_stall,
    output logic                                        o_out_valid,
    output logic                                        o_out_hit,
    output logic [((MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1)-1:0] o_raddr,
    output rrot_pkg::t_cmd                              o_cmd
);
    import rrot_pkg::*;

    localparam int AddrW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam logic [8:0] MaxN = 9'(MAX_OBSTACLES);

    t_state           r_state;
    t_state           n_state;
    logic [3:0]       r_step;
    logic [3:0]       n_step;
    logic [AddrW-1:0] r_idx;
    logic [AddrW-1:0] n_idx;
    logic [CntW-1:0]  r_count;
    logic             r_hit;
    logic             n_hit;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_out_hit;
    logic             n_out_hit;

    logic [8:0] w_cnt9;
    logic [8:0] w_scan_n;
    logic [8:0] w_idx9;
    logic       w_last;
    logic       w_accept;
    logic       w_out_free;

    assign w_cnt9     = {{(9-CntW){1'b0}}, r_count};
    assign w_scan_n   = (w_cnt9 > MaxN) ? MaxN : w_cnt9;
    assign w_idx9     = {{(9-AddrW){1'b0}}, r_idx};
    assign w_last     = (w_idx9 + 9'd1) == w_scan_n;
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_hit   = r_out_hit;
    assign o_raddr     = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_hit   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
            r_out_hit   <= n_out_hit;
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_idx          = r_idx;
        n_hit          = r_hit;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_hit      = r_out_hit;
        o_cmd.mop        = MOP_NONE;
        o_cmd.load_query = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_kind) begin
                    o_cmd.load_query = 1'b1;
                    n_step           = '0;
                    n_state          = S_SETUP;
                end
            end
            S_SETUP: begin
                case (r_step)
                    4'd0:    o_cmd.mop = MOP_DX;
                    4'd1:    o_cmd.mop = MOP_DY;
                    default: o_cmd.mop = MOP_NONE;
                endcase
                if (r_step == SetupLast) begin
                    n_idx = '0;
                    if (w_scan_n == 9'd0) begin
                        n_hit   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_FETCH: begin
                n_step  = '0;
                n_state = S_ENT;
            end
            S_ENT: begin
                case (r_step)
                    4'd0:    o_cmd.mop = MOP_IW;
                    4'd1:    o_cmd.mop = MOP_IL;
                    4'd2:    o_cmd.mop = MOP_PX0;
                    4'd3:    o_cmd.mop = MOP_PX1;
                    4'd4:    o_cmd.mop = MOP_PX2;
                    4'd5:    o_cmd.mop = MOP_PX3;
                    4'd6:    o_cmd.mop = MOP_PY0;
                    4'd7:    o_cmd.mop = MOP_PY1;
                    4'd8:    o_cmd.mop = MOP_PY2;
                    4'd9:    o_cmd.mop = MOP_PY3;
                    default: o_cmd.mop = MOP_NONE;
                endcase
                if (r_step == StepLast) begin
                    n_state = S_EVAL;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_EVAL: begin
                if (i_status.entry_hit) begin
                    n_hit   = 1'b1;
                    n_state = S_DONE;
                end else if (w_last) begin
                    n_hit   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + AddrW'(1);
                    n_state = S_FETCH;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_query_starts_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind) |=> (r_state == S_SETUP))
        else $error("query accept did not enter setup");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");

    a_eval_after_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state == S_ENT) && $past(r_step == StepLast)))
        else $error("entry evaluated before all products were written");

    a_step_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENT) |-> (r_step <= StepLast))
        else $error("entry step counter out of range");
`endif

endmodule
